### design/assert_macros.svh
// Assertion macros used by the checker module of the divider.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define ASSERT_RST(label, clock, rstn, prop) \
  label: assert property (@(posedge clock) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Check an implication on every rising clock edge outside of reset.
`define ASSERT_IMPL(label, clock, rstn, ante, cons) \
  label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

### design/udiv32_pkg.sv
// Package with the shared types and constants of the pipelined divider.
`timescale 1ns / 1ps

package udiv32_pkg;

  typedef struct packed {
    logic valid;
  } udiv_ctl_t;

  localparam int unsigned OUT_REG_STAGES = 1;

endpackage

### design/udiv32_stage.sv
// One registered restoring-division step that resolves a single quotient bit.
`timescale 1ns / 1ps

module udiv32_stage #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  udiv32_pkg::udiv_ctl_t  in_ctl,
  input  logic [DATA_WIDTH-1:0]  in_d,
  input  logic [DATA_WIDTH-1:0]  in_p,
  input  logic [DATA_WIDTH-1:0]  in_qn,
  output udiv32_pkg::udiv_ctl_t  out_ctl,
  output logic [DATA_WIDTH-1:0]  out_d,
  output logic [DATA_WIDTH-1:0]  out_p,
  output logic [DATA_WIDTH-1:0]  out_qn
);

  logic [DATA_WIDTH:0]    shifted;
  logic [DATA_WIDTH:0]    diff;
  logic                   fits;
  udiv32_pkg::udiv_ctl_t  ctl_r;
  logic [DATA_WIDTH-1:0]  d_r;
  logic [DATA_WIDTH-1:0]  p_r;
  logic [DATA_WIDTH-1:0]  qn_r;
  logic [DATA_WIDTH-1:0]  p_nxt;
  logic [DATA_WIDTH-1:0]  qn_nxt;

  always_comb begin
    shifted = {in_p, in_qn[DATA_WIDTH-1]};
    diff    = shifted - {1'b0, in_d};
    fits    = (shifted >= {1'b0, in_d});
    p_nxt   = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
    qn_nxt  = {in_qn[DATA_WIDTH-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    d_r  <= in_d;
    p_r  <= p_nxt;
    qn_r <= qn_nxt;
  end

  assign out_ctl = ctl_r;
  assign out_d   = d_r;
  assign out_p   = p_r;
  assign out_qn  = qn_r;

endmodule

### design/unsigned_divider_32.sv
// Top level of the pipelined restoring unsigned divider.
`timescale 1ns / 1ps

// Usage:
//   Drive in_divisor and in_numerator and raise start; the request is taken
//   at a rising edge where start is high and busy is low.
//   busy is high only while reset is applied and in the cycle after it,
//   so one request can be taken every clock cycle.
//   Each accepted request passes through the compare-and-subtract stages and
//   then the output register before out_valid strobes with out_quotient and
//   out_remainder. Throughput: one request per cycle.
//   The pipeline has one compare-and-subtract stage per quotient bit,
//   followed by an output register.
//   Dividing by zero gives an all-ones quotient and the numerator as the
//   remainder; dividing by one gives the numerator and a zero remainder.
//   The receiver cannot stall: each result shows for exactly one cycle.
//   Synchronous reset drops every request in flight.
module unsigned_divider_32 #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [DATA_WIDTH-1:0] in_divisor,
  input  logic [DATA_WIDTH-1:0] in_numerator,
  output logic                  out_valid,
  output logic [DATA_WIDTH-1:0] out_quotient,
  output logic [DATA_WIDTH-1:0] out_remainder
);

  udiv32_pkg::udiv_ctl_t  ctl   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0]  d_s   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0]  p_s   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0]  qn_s  [DATA_WIDTH+1];
  logic                   busy_r;
  logic                   busy_nxt;
  logic                   out_valid_r;
  logic [DATA_WIDTH-1:0]  out_quotient_r;
  logic [DATA_WIDTH-1:0]  out_remainder_r;

  assign busy_nxt = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r | ~rst_n;

  assign ctl[0].valid = start & ~busy;
  assign d_s[0]       = in_divisor;
  assign p_s[0]       = '0;
  assign qn_s[0]      = in_numerator;

  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_stage
    udiv32_stage #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_ctl  (ctl[k]),
      .in_d    (d_s[k]),
      .in_p    (p_s[k]),
      .in_qn   (qn_s[k]),
      .out_ctl (ctl[k+1]),
      .out_d   (d_s[k+1]),
      .out_p   (p_s[k+1]),
      .out_qn  (qn_s[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl[DATA_WIDTH].valid;
    end
  end

  always_ff @(posedge clk) begin
    out_quotient_r  <= qn_s[DATA_WIDTH];
    out_remainder_r <= p_s[DATA_WIDTH];
  end

  assign out_valid     = out_valid_r;
  assign out_quotient  = out_quotient_r;
  assign out_remainder = out_remainder_r;

endmodule

### design/udiv32_checker.sv
// Port-level checker for the divider and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module udiv32_checker #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic [DATA_WIDTH-1:0] in_divisor,
  input logic [DATA_WIDTH-1:0] in_numerator,
  input logic                  out_valid,
  input logic [DATA_WIDTH-1:0] out_quotient,
  input logic [DATA_WIDTH-1:0] out_remainder
);

  localparam int unsigned LAT    = DATA_WIDTH + udiv32_pkg::OUT_REG_STAGES;
  localparam int unsigned HIST_W = $clog2(LAT + 1);

  logic [HIST_W-1:0] hist_r;
  logic [HIST_W-1:0] hist_nxt;
  logic              settled;

  assign hist_nxt = (hist_r == HIST_W'(LAT)) ? hist_r : hist_r + 1'b1;
  assign settled  = (hist_r == HIST_W'(LAT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else begin
      hist_r <= hist_nxt;
    end
  end

  `ASSERT_IMPL(a_strobe_latency, clk, rst_n, settled, out_valid == $past(start && !busy, LAT))
  `ASSERT_IMPL(a_rem_below_div, clk, rst_n, settled && out_valid && ($past(in_divisor, LAT) != '0), out_remainder < $past(in_divisor, LAT))
  `ASSERT_IMPL(a_div_zero, clk, rst_n, settled && out_valid && ($past(in_divisor, LAT) == '0), (out_quotient == '1) && (out_remainder == $past(in_numerator, LAT)))
  `ASSERT_RST(a_ready_after_reset, clk, rst_n, $past(rst_n) |-> !busy)

endmodule

bind unsigned_divider_32 udiv32_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_udiv32_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_divisor    (in_divisor),
  .in_numerator  (in_numerator),
  .out_valid     (out_valid),
  .out_quotient  (out_quotient),
  .out_remainder (out_remainder)
);

### verif/unsigned_divider_32_tb.sv
// Self-checking testbench for the pipelined restoring unsigned divider.
`timescale 1ns / 1ps

module unsigned_divider_32_tb;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned PIPE_LATENCY = WIDTH + 1;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [WIDTH-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [WIDTH-1:0] quotient;
    logic [WIDTH-1:0] remainder;
  } division_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [WIDTH-1:0] in_divisor = '0;
  logic [WIDTH-1:0] in_numerator = '0;
  logic             out_valid;
  logic [WIDTH-1:0] out_quotient;
  logic [WIDTH-1:0] out_remainder;

  division_t   pending_divisions[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          idle_enable = 1'b1;

  unsigned_divider_32 #(.DATA_WIDTH(WIDTH)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_divisor   (in_divisor),
    .in_numerator (in_numerator),
    .out_valid    (out_valid),
    .out_quotient (out_quotient),
    .out_remainder(out_remainder)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic division_t restoring_divide(logic [WIDTH-1:0] divisor,
                                                 logic [WIDTH-1:0] numerator);
    division_t        res;
    logic [63:0]      partial;
    logic [63:0]      wide_divisor;
    res = '0;
    partial = {32'd0, numerator};
    wide_divisor = {32'd0, divisor};
    if (divisor == '0) begin
      res.quotient = ALL_ONES;
      res.remainder = numerator;
      return res;
    end
    for (int b = WIDTH - 1; b >= 0; b--) begin
      if (wide_divisor <= (partial >> b)) begin
        partial = partial - (wide_divisor << b);
        res.quotient[b] = 1'b1;
      end
    end
    res.remainder = partial[WIDTH-1:0];
    return res;
  endfunction

  function automatic void note_mismatch(string field, logic [WIDTH-1:0] exp_val,
                                        logic [WIDTH-1:0] act_val);
    mismatch_count++;
    $error("%s mismatch: expected %h, got %h", field, exp_val, act_val);
  endfunction

  always @(posedge clk) begin
    division_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_divisions.size() == 0) begin
          mismatch_count++;
          $error("unexpected result: quotient %h remainder %h",
                 out_quotient, out_remainder);
        end else begin
          want = pending_divisions.pop_front();
          if (out_quotient !== want.quotient)
            note_mismatch("quotient", want.quotient, out_quotient);
          if (out_remainder !== want.remainder)
            note_mismatch("remainder", want.remainder, out_remainder);
        end
      end
      if (start && !busy)
        pending_divisions.push_back(restoring_divide(in_divisor, in_numerator));
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_request(logic [WIDTH-1:0] divisor, logic [WIDTH-1:0] numerator);
    int unsigned gap;
    if (idle_enable && $urandom_range(99) < 8) begin
      gap = $urandom_range(3, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_divisor <= divisor;
    in_numerator <= numerator;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [WIDTH-1:0] shaped_numerator();
    case ($urandom_range(5))
      0: return $urandom_range(255);
      1: return ALL_ONES - $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WIDTH-1:0] shaped_divisor(logic [WIDTH-1:0] numerator);
    case ($urandom_range(11))
      0: return '0;
      1: return 1;
      2: return $urandom_range(255, 2);
      3: return 1 << $urandom_range(WIDTH - 1);
      4: return numerator + $urandom_range(2);
      5: return numerator - $urandom_range(2);
      6: return numerator >> $urandom_range(WIDTH - 1);
      7: return ALL_ONES - $urandom_range(1);
      8: return $urandom >> $urandom_range(WIDTH - 1);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_request(0, 0);
    send_request(0, ALL_ONES);
    send_request(0, 32'h8000_0000);
    send_request(1, 0);
    send_request(1, ALL_ONES);
    send_request(1, 32'h1234_5678);
    send_request(ALL_ONES, ALL_ONES);
    send_request(ALL_ONES, ALL_ONES - 1);
    send_request(ALL_ONES, 0);
    send_request(2, ALL_ONES);
    send_request(32'h8000_0000, ALL_ONES);
    send_request(32'h8000_0000, 32'h7FFF_FFFF);
    send_request(3, 10);
    send_request(7, 7);
    send_request(7, 6);
    send_request(32'h0001_0000, ALL_ONES);
    send_request(32'h0000_FFFF, ALL_ONES - 1);
    send_request(32'h5555_5555, 32'hAAAA_AAAA);
    send_request(32'hAAAA_AAAA, 32'h5555_5555);
    send_request(13, 0);
  endtask

  task automatic test_random_operands(int unsigned count);
    repeat (count) send_request($urandom, $urandom);
  endtask

  task automatic test_shaped_operands(int unsigned count);
    logic [WIDTH-1:0] n;
    repeat (count) begin
      n = shaped_numerator();
      send_request(shaped_divisor(n), n);
    end
  endtask

  task automatic test_back_to_back(int unsigned count);
    logic [WIDTH-1:0] n;
    idle_enable = 1'b0;
    repeat (count) begin
      n = shaped_numerator();
      send_request(shaped_divisor(n), n);
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_operands(600);
    test_shaped_operands(900);
    test_back_to_back(400);
    start <= 1'b0;
    while (pending_divisions.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
